### hw/rtl/weighted_group_fifo_defines.svh
// Assertion macros used by the queue core RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WEIGHTED_GROUP_FIFO_DEFINES_SVH
`define WEIGHTED_GROUP_FIFO_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("queue invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define WGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("queue step check failed");

`endif

### hw/rtl/wgf_pkg.sv
`timescale 1ns / 1ps

package wgf_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    localparam int CMD_W  = 2;
    localparam int ID_W   = 10;
    localparam int SIZE_W = 8;
    localparam int STAMP_W = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int SUM_W  = 12;
    localparam int CLS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CLS_W-1:0] CLS_BOTH    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_TOUR    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_COURIER = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [SIZE_W-1:0]  size;
        logic               kind;
        logic [ID_W-1:0]    id;
    } t_entry;

    typedef struct packed {
        t_entry             ent;
        logic [CMD_W-1:0]   cmd;
    } t_in_item;

    typedef struct packed {
        logic               en;
        logic [AW-1:0]      addr;
        t_entry             ent;
    } t_wr_req;

    typedef struct packed {
        logic [CLS_W-1:0]   admit_class;
        logic [SUM_W-1:0]   persons_total;
        logic [ID_W-1:0]    head_id;
        logic               head_valid;
        logic [ID_W-1:0]    removed_id;
        logic [SLOT_W-1:0]  slot;
        logic [STAT_W-1:0]  status;
    } t_result;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

endpackage

### hw/rtl/wgf_store.sv
`timescale 1ns / 1ps

// Entry memory: one write port, two registered read ports. A write that hits
// a read address in the same cycle is forwarded, so the read data always
// reflects the memory after that edge.
module wgf_store (
    input  logic                 i_clk,
    input  wgf_pkg::t_wr_req     i_wr,
    input  logic [wgf_pkg::AW-1:0] i_rd_head_addr,
    input  logic [wgf_pkg::AW-1:0] i_rd_next_addr,
    output wgf_pkg::t_entry      o_head_ent,
    output wgf_pkg::t_entry      o_next_ent
);
    import wgf_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_head_ent;
    t_entry r_next_ent;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == i_rd_head_addr)) begin
            r_head_ent <= i_wr.ent;
        end else begin
            r_head_ent <= r_mem[i_rd_head_addr];
        end
        if (i_wr.en && (i_wr.addr == i_rd_next_addr)) begin
            r_next_ent <= i_wr.ent;
        end else begin
            r_next_ent <= r_mem[i_rd_next_addr];
        end
    end

    assign o_head_ent = r_head_ent;
    assign o_next_ent = r_next_ent;

endmodule

### hw/rtl/wgf_core.sv
`timescale 1ns / 1ps
`include "weighted_group_fifo_defines.svh"

// Pointers, counters and the per-command result logic.
module wgf_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  wgf_pkg::t_in_item      i_item,
    input  wgf_pkg::t_entry        i_head_ent,
    input  wgf_pkg::t_entry        i_next_ent,
    output wgf_pkg::t_wr_req       o_wr,
    output logic [wgf_pkg::AW-1:0] o_rd_head_addr,
    output logic [wgf_pkg::AW-1:0] o_rd_next_addr,
    output wgf_pkg::t_result       o_result
);
    import wgf_pkg::*;

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_fill, n_fill;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CW-1:0]    r_tours, n_tours;

    logic             w_wr_ok;
    logic [ID_W-1:0]  w_hid;
    logic [AW-1:0]    w_head_addr;
    t_result          w_res;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_tours = r_tours;
        w_wr_ok = 1'b0;
        w_hid   = i_head_ent.id;
        w_res   = '0;
        w_res.status = ST_OK;

        case (i_item.cmd)
            CMD_ENQ: begin
                if (r_fill == CW'(DEPTH)) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_wr_ok    = 1'b1;
                    w_res.slot = SLOT_W'(r_tail);
                    n_tail     = ptr_inc(r_tail);
                    n_fill     = r_fill + CW'(1);
                    n_sum      = r_sum + SUM_W'(i_item.ent.size);
                    n_tours    = r_tours + CW'(i_item.ent.kind);
                    // Into an empty queue the new entry becomes the head.
                    if (r_fill == '0) begin
                        w_hid = i_item.ent.id;
                    end
                end
            end
            CMD_DEQ: begin
                if (r_fill == '0) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_res.removed_id = i_head_ent.id;
                    n_fill = r_fill - CW'(1);
                    w_hid  = i_next_ent.id;
                    if (r_fill == CW'(1)) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_sum   = '0;
                        n_tours = '0;
                    end else begin
                        n_head  = ptr_inc(r_head);
                        n_sum   = r_sum - SUM_W'(i_head_ent.size);
                        n_tours = r_tours - CW'(i_head_ent.kind);
                    end
                end
            end
            default: begin
                // Status query and the unused code leave the state alone.
            end
        endcase

        w_res.head_valid = (n_fill != '0);
        w_res.head_id    = w_res.head_valid ? w_hid : '0;
        w_res.persons_total = w_res.head_valid ? n_sum : '0;
        if (!w_res.head_valid) begin
            w_res.admit_class = CLS_BOTH;
        end else if (n_tours != '0) begin
            w_res.admit_class = CLS_TOUR;
        end else begin
            w_res.admit_class = CLS_COURIER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_tours <= '0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_tours <= n_tours;
        end
    end

    // The read ports track the head as it will be after this edge.
    assign w_head_addr    = i_step ? n_head : r_head;
    assign o_rd_head_addr = w_head_addr;
    assign o_rd_next_addr = ptr_inc(w_head_addr);

    assign o_wr.en   = i_step && w_wr_ok;
    assign o_wr.addr = r_tail;
    assign o_wr.ent  = i_item.ent;

    assign o_result = w_res;

    `WGF_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CW'(DEPTH))
    `WGF_ASSERT_NOW(a_empty_clean, r_fill == '0,
        (r_head == '0) && (r_tail == '0) && (r_sum == '0) && (r_tours == '0))
    `WGF_ASSERT_NOW(a_tours_bound, 1'b1, r_tours <= r_fill)
    `WGF_ASSERT_NOW(a_ptr_span, 1'b1, r_tail == AW'(r_head + r_fill[AW-1:0]))
    `WGF_ASSERT_NEXT(a_full_holds, i_step && (i_item.cmd == CMD_ENQ) && (r_fill == CW'(DEPTH)),
        $stable(r_tail) && $stable(r_fill))

endmodule

### hw/rtl/weighted_group_fifo.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (low bit up)                 tuser fields
// s_axis    in         entry_id, group_size, stamp               command, group_kind
// m_axis    out        status, slot, removed_id, head_valid,     -
//                      head_id, persons_total, admit_class
//
// One item per cycle is sustained while m_axis_tready holds: an accepted item sits in
// the input register until the queue state and the result register update together.
// Each item goes from the input register to the result register, which drives m_axis.
// The entry memory's registered read ports are pointed at the next head, so no read wait
// is added.
// A stalled result holds the input register, and the input register empties as soon as
// its item moves on.
// Reset is synchronous and active low; it empties the queue, and no clearing pass is made.
module weighted_group_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // entry_id, group_size, stamp, zero pad
    input  logic [2:0]  s_axis_tuser,   // command, group_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, slot, removed_id, head_valid, head_id,
                                        // persons_total, admit_class, zero pad
);
    import wgf_pkg::*;

    t_in_item r_in;
    logic     r_in_vld;
    t_result  r_out;
    logic     r_out_vld;

    logic     w_step;
    logic     w_take;
    t_wr_req  w_wr;
    logic [AW-1:0] w_rd_head_addr;
    logic [AW-1:0] w_rd_next_addr;
    t_entry   w_head_ent;
    t_entry   w_next_ent;
    t_result  w_res;

    assign w_step        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_step;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_step) begin
                r_in_vld <= 1'b0;
            end
            if (w_step) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.cmd       <= s_axis_tuser[1:0];
            r_in.ent.kind  <= s_axis_tuser[2];
            r_in.ent.id    <= s_axis_tdata[9:0];
            r_in.ent.size  <= s_axis_tdata[17:10];
            r_in.ent.stamp <= s_axis_tdata[49:18];
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    wgf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_in),
        .i_head_ent     (w_head_ent),
        .i_next_ent     (w_next_ent),
        .o_wr           (w_wr),
        .o_rd_head_addr (w_rd_head_addr),
        .o_rd_next_addr (w_rd_next_addr),
        .o_result       (w_res)
    );

    wgf_store u_store (
        .i_clk          (i_clk),
        .i_wr           (w_wr),
        .i_rd_head_addr (w_rd_head_addr),
        .i_rd_next_addr (w_rd_next_addr),
        .o_head_ent     (w_head_ent),
        .o_next_ent     (w_next_ent)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule
